// ===== rtl/artff_pkg.sv =====
// Package: types, constants and state codes for the address region table.
package artff_pkg;

	localparam int unsigned MaxRegionsDef = 64;

	typedef enum logic [1:0] {
		REQ_SEARCH = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_LOOKUP = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOFIT = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] req_addr;
		logic [31:0] req_size;
		logic [31:0] window_low;
		logic [31:0] window_high;
		logic        desired_valid;
		logic        exact_only;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] out_addr;
		logic [31:0] out_size;
	} out_word_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_EVAL,
		S_GAP,
		S_PRB,
		S_SHR,
		S_SHW,
		S_PUT,
		S_SHLR,
		S_SHLW,
		S_OUT
	} state_t;

	typedef struct packed {
		logic        isz_ok;
		logic [32:0] is;
		logic        des_ok;
		logic [31:0] ds;
	} probe_res_t;

endpackage

// ===== rtl/address_region_table_first_fit_unit.sv =====
// Top level: first-fit region table with a sequencer over one table memory.
// Requests are served one at a time: in_stall stays high from acceptance until the result
// word is loaded into the output register. A search walks each stored entry through a read,
// a gap clip and a desired-block test; a lookup walks each entry through a read and a
// compare; an insert or remove walks entries with a read and a compare, then moves each
// shifted entry with a read and a write.
module address_region_table_first_fit_unit #(
	parameter int unsigned MAX_REGIONS = artff_pkg::MaxRegionsDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  artff_pkg::in_word_t  in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output artff_pkg::out_word_t out_word
);
	import artff_pkg::*;

	localparam int AW = $clog2(MAX_REGIONS);
	localparam int CW = $clog2(MAX_REGIONS + 1);

	logic [63:0]   mem [MAX_REGIONS];
	logic [63:0]   rd_q;
	logic          we;
	logic [AW-1:0] wa, ra;
	logic [63:0]   wd;

	state_t        st_q, st_d;
	in_word_t      req_q;
	logic [CW-1:0] cnt_q, i_q, pos_q;
	logic [32:0]   gs_q;
	logic          found_q;
	logic [31:0]   pot_q;
	out_word_t     res_q, out_q;
	logic          out_v_q;

	logic [32:0]   gs_w, ge_w;
	probe_res_t    pr;
	logic [32:0]   rstart, rend, req_a, req_end;
	logic          ins_hit, rem_hit, look_hit;
	logic          last_i;
	logic [CW-1:0] i_dn, i_up;
	logic          found_n, done_p, keep_p;
	logic [31:0]   pot_n, grant_p;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	artff_probe u_probe (.clk(clk), .gs(gs_w), .ge(ge_w), .req(req_q), .res(pr));

	always_comb begin
		rstart = {1'b0, rd_q[63:32]};
		rend = rstart + {1'b0, rd_q[31:0]};
		req_a = {1'b0, req_q.req_addr};
		req_end = req_a + {1'b0, req_q.req_size};
		ins_hit = rd_q[63:32] >= req_q.req_addr;
		rem_hit = (req_a >= rstart) && (req_end <= rend);
		look_hit = (req_a >= rstart) && (req_a < rend);
		gs_w = gs_q;
		ge_w = (st_q == S_GAP) ? 33'h100000000 : rstart;
		last_i = i_q >= cnt_q;
		i_dn = i_q - CW'(1);
		i_up = i_q + CW'(1);
		found_n = found_q | pr.isz_ok;
		pot_n = pr.isz_ok ? pr.is[31:0] : pot_q;
		done_p = pr.isz_ok && (!req_q.desired_valid || pr.des_ok);
		grant_p = req_q.desired_valid ? pr.ds : pr.is[31:0];
		keep_p = found_n && !(req_q.exact_only && req_q.desired_valid &&
			pot_n != req_q.req_addr);
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: if (in_valid) st_d = S_RD;
			S_RD: begin
				case (req_q.req_type)
					REQ_SEARCH: begin
						if (req_q.req_size == 32'd0) st_d = S_OUT;
						else if (last_i) st_d = S_GAP;
						else st_d = S_EVAL;
					end
					REQ_INSERT: begin
						if (cnt_q >= CW'(MAX_REGIONS)) st_d = S_OUT;
						else if (last_i) st_d = S_SHR;
						else st_d = S_EVAL;
					end
					default: st_d = last_i ? S_OUT : S_EVAL;
				endcase
			end
			S_EVAL: begin
				case (req_q.req_type)
					REQ_SEARCH: st_d = S_PRB;
					REQ_INSERT: st_d = ins_hit ? S_SHR : S_RD;
					REQ_REMOVE: begin
						if (!rem_hit) st_d = S_RD;
						else if (i_up < cnt_q) st_d = S_SHLR;
						else st_d = S_OUT;
					end
					default: st_d = look_hit ? S_OUT : S_RD;
				endcase
			end
			S_GAP: st_d = S_PRB;
			S_PRB: st_d = (done_p || last_i) ? S_OUT : S_RD;
			S_SHR: st_d = (i_q == pos_q) ? S_PUT : S_SHW;
			S_SHW: st_d = S_SHR;
			S_PUT: st_d = S_OUT;
			S_SHLR: st_d = S_SHLW;
			S_SHLW: st_d = (i_up >= cnt_q) ? S_OUT : S_SHLR;
			S_OUT: if (!out_v_q || !out_stall) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	assign in_stall = (st_q != S_IDLE);
	assign out_valid = out_v_q;
	assign out_word = out_q;

	always_comb begin
		we = 1'b0;
		wa = i_q[AW-1:0];
		wd = rd_q;
		ra = i_q[AW-1:0];
		case (st_q)
			S_SHR: if (i_q != pos_q) ra = i_dn[AW-1:0];
			S_SHW: we = 1'b1;
			S_PUT: begin
				we = 1'b1;
				wd = {req_q.req_addr, req_q.req_size};
			end
			S_SHLR: ra = i_up[AW-1:0];
			S_SHLW: we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == S_OUT && st_d == S_IDLE) out_v_q <= 1'b1;
			else if (!out_stall) out_v_q <= 1'b0;
			if (st_q == S_PUT) cnt_q <= cnt_q + CW'(1);
			if (st_q == S_EVAL && req_q.req_type == REQ_REMOVE && rem_hit)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				req_q <= in_word;
				i_q <= '0;
				gs_q <= '0;
				found_q <= 1'b0;
				pot_q <= '0;
				res_q <= '{status: ST_NOFIT, out_addr: 32'd0, out_size: 32'd0};
			end
			S_RD: begin
				if (req_q.req_type == REQ_INSERT) begin
					if (cnt_q >= CW'(MAX_REGIONS)) res_q.status <= ST_FULL;
					else if (last_i) pos_q <= i_q;
				end
			end
			S_EVAL: begin
				gs_q <= rend;
				case (req_q.req_type)
					REQ_SEARCH: ;
					REQ_INSERT: begin
						if (ins_hit) begin
							pos_q <= i_q;
							i_q <= cnt_q;
						end else i_q <= i_up;
					end
					REQ_REMOVE: begin
						if (rem_hit)
							res_q <= '{status: ST_OK, out_addr: rd_q[63:32], out_size: rd_q[31:0]};
						else i_q <= i_up;
					end
					default: begin
						if (look_hit)
							res_q <= '{status: ST_OK, out_addr: rd_q[63:32], out_size: rd_q[31:0]};
						else i_q <= i_up;
					end
				endcase
			end
			S_PRB: begin
				found_q <= found_n;
				pot_q <= pot_n;
				if (!last_i) i_q <= i_up;
				if (done_p) begin
					res_q.status <= ST_OK;
					res_q.out_addr <= grant_p;
				end else if (last_i && keep_p) begin
					res_q.status <= ST_OK;
					res_q.out_addr <= pot_n;
				end
			end
			S_SHW: i_q <= i_dn;
			S_PUT: res_q.status <= ST_OK;
			S_SHLW: i_q <= i_up;
			S_OUT: if (!out_v_q || !out_stall) out_q <= res_q;
			default: ;
		endcase
	end

endmodule

// ===== rtl/artff_probe.sv =====
// Gap probe: clip one gap to the window, register it, then test the desired block.
module artff_probe (
	input  logic                  clk,
	input  logic [32:0]           gs,
	input  logic [32:0]           ge,
	input  artff_pkg::in_word_t   req,
	output artff_pkg::probe_res_t res
);
	import artff_pkg::*;

	logic [33:0] gsz, isz, rs, re, cs;
	logic [33:0] isz_s1, cs_s1;
	logic [33:0] bsz, dsz, de, iend;

	function automatic logic [33:0] clip_len(input logic [33:0] bs, input logic [33:0] sz,
		input logic [33:0] r0, input logic [33:0] r1, output logic [33:0] os);
		logic [33:0] e;
		begin
			e = bs + sz - 34'd1;
			os = 34'd0;
			clip_len = 34'd0;
			if (sz != 34'd0 && r1 > r0 && e <= 34'hFFFFFFFF && !(bs >= r1 || e <= r0)) begin
				if (bs >= r0 && e <= r1) begin
					os = bs; clip_len = e - bs + 34'd1;
				end else if (r0 >= bs && r1 <= e) begin
					os = r0; clip_len = r1 - r0 + 34'd1;
				end else if (bs >= r0) begin
					os = bs; clip_len = r1 - bs + 34'd1;
				end else begin
					os = r0; clip_len = e - r0 + 34'd1;
				end
			end
		end
	endfunction

	always_comb begin
		gsz = ({1'b0, ge} > {1'b0, gs} && !gs[32]) ? ({1'b0, ge} - {1'b0, gs}) : 34'd0;
		rs = {2'b0, req.window_low};
		re = {2'b0, req.window_high};
		isz = clip_len({1'b0, gs}, gsz, rs, re, cs);
	end

	always_ff @(posedge clk) begin
		isz_s1 <= isz;
		cs_s1 <= cs;
	end

	always_comb begin
		bsz = {2'b0, req.req_size};
		iend = cs_s1 + isz_s1 - 34'd1;
		dsz = clip_len({2'b0, req.req_addr}, bsz, cs_s1, iend, de);
		res.isz_ok = (isz_s1 != 34'd0) && (isz_s1 >= bsz);
		res.is = cs_s1[32:0];
		res.des_ok = dsz >= bsz;
		res.ds = de[31:0];
	end
endmodule
